### rtl/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared types and constants for the point box crop block: payload structs,
// register indexes and the command and status groups between control and
// datapath.
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int CoordBits = 20;
  localparam int CountBits = 18;
  localparam int MaxPoints = 131072;
  localparam int SqBits    = 2 * CoordBits + 2;
  localparam int RootBits  = CoordBits + 1;
  localparam int RootSteps = RootBits;
  localparam int StepBits  = $clog2(RootSteps);
  localparam int CfgIdxBits = 3;

  localparam logic signed [CoordBits-1:0] XLowerRst = CoordBits'(400);
  localparam logic signed [CoordBits-1:0] XUpperRst = CoordBits'(7000);
  localparam logic signed [CoordBits-1:0] YLowerRst = -CoordBits'(7000);
  localparam logic signed [CoordBits-1:0] YUpperRst = CoordBits'(7000);
  localparam logic signed [CoordBits-1:0] ZLowerRst = -CoordBits'(4000);
  localparam logic signed [CoordBits-1:0] ZUpperRst = CoordBits'(4000);
  localparam logic [CountBits-1:0]        MinPointsRst = CountBits'(256);

  typedef enum logic [CfgIdxBits-1:0] {
    CfgXLower    = 3'd0,
    CfgXUpper    = 3'd1,
    CfgYLower    = 3'd2,
    CfgYUpper    = 3'd3,
    CfgZLower    = 3'd4,
    CfgZUpper    = 3'd5,
    CfgMinPoints = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SelX = 2'd0,
    SelY = 2'd1,
    SelZ = 2'd2,
    SelAcc = 2'd3
  } sq_sel_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] px;
    logic signed [CoordBits-1:0] py;
    logic signed [CoordBits-1:0] pz;
    logic                        frame_end;
  } pbc_in_t;

  typedef struct packed {
    logic                        kind;
    logic signed [CoordBits-1:0] out_x;
    logic signed [CoordBits-1:0] out_y;
    logic signed [CoordBits-1:0] out_z;
    logic [CoordBits-1:0]        nearest_distance;
    logic                        none_kept;
    logic [CountBits-1:0]        kept_count;
    logic                        short_frame;
    logic                        run_last;
  } pbc_out_t;

  typedef struct packed {
    logic    in_load;
    logic    sq_en;
    sq_sel_e sq_sel;
    logic    upd_en;
    logic    out_load_pt;
    logic    root_init;
    logic    root_step;
    logic    out_load_sum;
  } pbc_cmd_t;

  typedef struct packed {
    logic in_box;
    logic frame_end;
    logic out_busy;
  } pbc_sts_t;

endpackage

### rtl/pbc_ctrl.sv
// ----------------------------------------------------------------------------
// pbc_ctrl
// Sequencer for the point box crop block: box check, squared distance over a
// shared multiplier, nearest update, result transfers and the frame-end root.
// ----------------------------------------------------------------------------
module pbc_ctrl
  import pbc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pbc_sts_t sts_i,
  output pbc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SQ,
    S_UPD,
    S_PT,
    S_ROOT,
    S_SUM
  } state_e;

  state_e              state_q, state_d;
  logic [StepBits-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.sq_sel = SelX;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_d = '0;
        if (sts_i.in_box) begin
          state_d = S_SQ;
        end else if (sts_i.frame_end) begin
          cmd_o.root_init = 1'b1;
          state_d         = S_ROOT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SQ: begin
        cmd_o.sq_en  = 1'b1;
        cmd_o.sq_sel = sq_sel_e'(cnt_q[1:0]);
        if (cnt_q[1:0] == SelAcc) begin
          cnt_d   = '0;
          state_d = S_UPD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_UPD: begin
        cmd_o.upd_en = 1'b1;
        state_d      = S_PT;
      end
      S_PT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load_pt = 1'b1;
          cnt_d             = '0;
          if (sts_i.frame_end) begin
            cmd_o.root_init = 1'b1;
            state_d         = S_ROOT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == StepBits'(RootSteps - 1)) begin
          state_d = S_SUM;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SUM: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load_sum = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### rtl/pbc_dpath.sv
// ----------------------------------------------------------------------------
// pbc_dpath
// Datapath of the point box crop block: box registers, input and output
// registers, shared squarer, nearest point state and a bit-pair square root.
// ----------------------------------------------------------------------------
module pbc_dpath
  import pbc_pkg::*;
#(
  parameter int MAX_POINTS = MaxPoints
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CoordBits-1:0]  cfg_data_i,
  input  pbc_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pbc_out_t              out_data_o,
  input  pbc_cmd_t              cmd_i,
  output pbc_sts_t              sts_o
);

  localparam int CntBits = $clog2(MAX_POINTS + 1);
  localparam int ExtBits = CntBits + CountBits;

  logic signed [CoordBits-1:0] x_lo_q, x_hi_q, y_lo_q, y_hi_q, z_lo_q, z_hi_q;
  logic [CountBits-1:0]        min_pts_q;

  pbc_in_t                     in_q;
  pbc_out_t                    out_q, out_d;
  logic                        out_valid_q, out_valid_d;

  logic [CoordBits-1:0]        sq_op, sq_mag;
  logic [2*CoordBits-1:0]      prod_q;
  logic [SqBits-1:0]           acc_q;

  logic [CntBits-1:0]          kept_q;
  logic [SqBits-1:0]           best_sq_q;
  logic signed [CoordBits-1:0] best_x_q, best_y_q, best_z_q;
  logic                        have_q;

  logic [SqBits-1:0]           rad_q;
  logic [RootBits+1:0]         rem_q, rem_sh, trial;
  logic [RootBits-1:0]         root_q;
  logic [CoordBits-1:0]        root_dist;
  logic [ExtBits-1:0]          kept_ext, min_ext;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_lo_q    <= XLowerRst;
      x_hi_q    <= XUpperRst;
      y_lo_q    <= YLowerRst;
      y_hi_q    <= YUpperRst;
      z_lo_q    <= ZLowerRst;
      z_hi_q    <= ZUpperRst;
      min_pts_q <= MinPointsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgXLower:    x_lo_q    <= cfg_data_i;
        CfgXUpper:    x_hi_q    <= cfg_data_i;
        CfgYLower:    y_lo_q    <= cfg_data_i;
        CfgYUpper:    y_hi_q    <= cfg_data_i;
        CfgZLower:    z_lo_q    <= cfg_data_i;
        CfgZUpper:    z_hi_q    <= cfg_data_i;
        CfgMinPoints: min_pts_q <= cfg_data_i[CountBits-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      in_q <= in_data_i;
    end
  end

  assign sts_o.in_box = (in_q.px > x_lo_q) && (in_q.px < x_hi_q) &&
                        (in_q.py > y_lo_q) && (in_q.py < y_hi_q) &&
                        (in_q.pz > z_lo_q) && (in_q.pz < z_hi_q);
  assign sts_o.frame_end = in_q.frame_end;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  // squared distance: one square per cycle, each square accumulated in the cycle after
  always_comb begin
    case (cmd_i.sq_sel)
      SelX:    sq_op = in_q.px;
      SelY:    sq_op = in_q.py;
      SelZ:    sq_op = in_q.pz;
      default: sq_op = '0;
    endcase
    sq_mag = sq_op[CoordBits-1] ? (~sq_op + 1'b1) : sq_op;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      prod_q <= sq_mag * sq_mag;
      if (cmd_i.sq_sel == SelX) begin
        acc_q <= '0;
      end else begin
        acc_q <= acc_q + SqBits'(prod_q);
      end
    end
  end

  // nearest point and kept count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q    <= '0;
      best_sq_q <= '1;
      best_x_q  <= '0;
      best_y_q  <= '0;
      best_z_q  <= '0;
      have_q    <= 1'b0;
    end else if (cmd_i.out_load_sum) begin
      kept_q    <= '0;
      best_sq_q <= '1;
      best_x_q  <= '0;
      best_y_q  <= '0;
      best_z_q  <= '0;
      have_q    <= 1'b0;
    end else if (cmd_i.upd_en) begin
      if (kept_q < CntBits'(MAX_POINTS)) begin
        kept_q <= kept_q + 1'b1;
      end
      if (!have_q || (acc_q < best_sq_q)) begin
        best_sq_q <= acc_q;
        best_x_q  <= in_q.px;
        best_y_q  <= in_q.py;
        best_z_q  <= in_q.pz;
        have_q    <= 1'b1;
      end
    end
  end

  // integer square root, two radicand bits per step
  assign rem_sh = {rem_q[RootBits-1:0], rad_q[SqBits-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      rad_q  <= best_sq_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q <= rad_q << 2;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[RootBits-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[RootBits-2:0], 1'b0};
      end
    end
  end

  assign root_dist = (!have_q || root_q[RootBits-1]) ? '1 : root_q[CoordBits-1:0];
  assign kept_ext  = ExtBits'(kept_q);
  assign min_ext   = ExtBits'(min_pts_q);

  // result register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load_pt) begin
      out_d          = '0;
      out_d.out_x    = in_q.px;
      out_d.out_y    = in_q.py;
      out_d.out_z    = in_q.pz;
      out_d.run_last = !in_q.frame_end;
      out_valid_d    = 1'b1;
    end else if (cmd_i.out_load_sum) begin
      out_d.kind             = 1'b1;
      out_d.out_x            = best_x_q;
      out_d.out_y            = best_y_q;
      out_d.out_z            = best_z_q;
      out_d.nearest_distance = root_dist;
      out_d.none_kept        = !have_q;
      out_d.kept_count       = kept_ext[CountBits-1:0];
      out_d.short_frame      = kept_ext < min_ext;
      out_d.run_last         = 1'b1;
      out_valid_d            = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/point_box_crop_nearest_point.sv
// ----------------------------------------------------------------------------
// point_box_crop_nearest_point
// Crops lidar points to a box, passes kept points on and reports the nearest
// kept point, its distance and the kept count at each frame end.
//
//   channel   direction  signals                         transfer when
//   in        input      in_valid_i/in_ready_o/in_data_i  valid & ready
//   out       output     out_valid_o/out_ready_i/out_data_o valid & ready
//   cfg       input      cfg_we_i/cfg_idx_i/cfg_data_i    cfg_we_i
//
// A point outside the box passes the idle and check states; a kept point also
// runs the squarer steps, the nearest update and the result load, plus any wait
// on the result register. Frame end adds the square root unit (one result bit per cycle) and the summary transfer.
// A new point is accepted while a result still waits in the output register.
// Reset restores the default box and clears the frame state at once.
// ----------------------------------------------------------------------------
module point_box_crop_nearest_point
  import pbc_pkg::*;
#(
  parameter int MAX_POINTS = MaxPoints
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CoordBits-1:0]  cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pbc_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pbc_out_t              out_data_o
);

  pbc_cmd_t cmd;
  pbc_sts_t sts;

  pbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pbc_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
